### rtl/prefix_code_bit_packer_assert.svh
// Assertion macros for the prefix code bit packer checker.
// Clock aclk and active-low reset aresetn are taken from the including scope.
`ifndef PREFIX_CODE_BIT_PACKER_ASSERT_SVH
`define PREFIX_CODE_BIT_PACKER_ASSERT_SVH

// same-cycle implication
`define PCBP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define PCBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

### rtl/pcbp_pkg.sv
// Shared types and constants for the prefix code bit packer.
// No dependencies.
`default_nettype none

package pcbp_pkg;

    localparam int OP_W    = 2;
    localparam int SYM_W   = 8;
    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 32;
    localparam int PEND_W  = 7;
    localparam int PCNT_W  = 3;
    localparam int ACC_W   = CODE_W + PEND_W;
    localparam int NB_W    = 3;

    localparam int MAX_CODE_LEN = 32;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } entry_t;

    // one item handed to the byte emitter
    typedef struct packed {
        logic [CODE_W-1:0] word;      // bytes left aligned, first in [31:24]
        logic [NB_W-1:0]   nbytes;    // 0 gives a single row without a byte
        logic              err;
        logic              clear_cnt; // block ends after this item
    } emit_item_t;

endpackage

`default_nettype wire

### rtl/pcbp_code_table.sv
// Code table: symbol code and length memory with per-entry valid bits.
// Depends on pcbp_pkg. Read data is registered; invalid entries read as zero.
`default_nettype none

module pcbp_code_table #(
    parameter int SYMBOL_COUNT = 256,
    parameter int IDX_W        = 8
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 wr_en,
    input  wire [IDX_W-1:0]     wr_idx,
    input  pcbp_pkg::entry_t    wr_entry,
    input  wire                 rd_en,
    input  wire [IDX_W-1:0]     rd_idx,
    input  wire                 rd_in_range,
    output pcbp_pkg::entry_t    rd_entry
);
    import pcbp_pkg::*;

    entry_t mem [SYMBOL_COUNT];
    entry_t rd_q_reg;
    logic   valid_reg [SYMBOL_COUNT];
    logic   rd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_entry;
        end
        if (rd_en) begin
            rd_q_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SYMBOL_COUNT; i++) begin
                valid_reg[i] <= 1'b0;
            end
            rd_hit_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en) begin
                rd_hit_reg <= rd_in_range && valid_reg[rd_idx];
            end
        end
    end

    assign rd_entry = rd_hit_reg ? rd_q_reg : '0;

endmodule

`default_nettype wire

### rtl/pcbp_bit_align.sv
// Input stage and bit alignment: holds pending bits and builds emitter items.
// Depends on pcbp_pkg.
`default_nettype none

module pcbp_bit_align (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        in_valid,
    input  wire [pcbp_pkg::OP_W-1:0]   in_op,
    input  wire                        in_err,
    output logic                       in_ready,
    input  pcbp_pkg::entry_t           tbl_entry,
    output logic                       item_valid,
    output pcbp_pkg::emit_item_t       item,
    input  wire                        item_take
);
    import pcbp_pkg::*;

    logic              s1_valid_reg, s1_valid_next;
    logic [OP_W-1:0]   s1_op_reg;
    logic              s1_err_reg;
    logic [PEND_W-1:0] pend_bits_reg, pend_bits_next;
    logic [PCNT_W-1:0] pend_cnt_reg, pend_cnt_next;

    logic              advance;
    logic [LEN_W-1:0]  clen;
    logic [LEN_W-1:0]  total;
    logic [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]  acc_l;
    logic [BYTE_W-1:0] flush_byte;

    always_comb begin
        advance    = s1_valid_reg && item_take;
        in_ready   = !s1_valid_reg || item_take;
        item_valid = s1_valid_reg;

        clen  = (s1_op_reg == OP_ENCODE) ? tbl_entry.len : '0;
        acc   = (ACC_W'(pend_bits_reg) << clen) | ACC_W'(tbl_entry.code);
        total = LEN_W'(pend_cnt_reg) + clen;
        acc_l = acc << (LEN_W'(ACC_W) - total);
        flush_byte = BYTE_W'({1'b0, pend_bits_reg} << (4'd8 - {1'b0, pend_cnt_reg}));

        item           = '0;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;

        unique case (s1_op_reg)
            OP_LOAD: begin
                item.err = s1_err_reg;
            end
            OP_ENCODE: begin
                item.word      = acc_l[ACC_W-1 -: CODE_W];
                item.nbytes    = total[LEN_W-1:3];
                pend_cnt_next  = total[2:0];
                pend_bits_next = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << total[2:0]);
            end
            OP_FLUSH: begin
                item.word      = {flush_byte, {(CODE_W-BYTE_W){1'b0}}};
                item.nbytes    = (pend_cnt_reg != '0) ? NB_W'(1) : '0;
                item.clear_cnt = 1'b1;
                pend_cnt_next  = '0;
                pend_bits_next = '0;
            end
            default: begin
            end
        endcase

        if (!advance) begin
            pend_bits_next = pend_bits_reg;
            pend_cnt_next  = pend_cnt_reg;
        end

        s1_valid_next = in_ready ? in_valid : s1_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            s1_op_reg  <= in_op;
            s1_err_reg <= in_err;
        end
    end

endmodule

`default_nettype wire

### rtl/pcbp_byte_emit.sv
// Byte emitter: one result row per cycle into the output register while m_ready is high.
// Depends on pcbp_pkg. Keeps the saturating block byte count.
`default_nettype none

module pcbp_byte_emit (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          item_valid,
    input  pcbp_pkg::emit_item_t         item,
    output logic                         item_take,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [pcbp_pkg::BYTE_W-1:0]  m_data_byte,
    output logic                         m_has_byte,
    output logic                         m_run_last,
    output logic [pcbp_pkg::CNT_W-1:0]   m_payload_length,
    output logic                         m_length_error
);
    import pcbp_pkg::*;

    logic              w_valid_reg, w_valid_next;
    logic [CODE_W-1:0] w_word_reg, w_word_next;
    logic [NB_W-1:0]   w_left_reg, w_left_next;
    logic              w_err_reg, w_err_next;
    logic              w_clear_reg, w_clear_next;
    logic [CNT_W-1:0]  byte_cnt_reg, byte_cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_data_reg;
    logic              m_has_reg, m_last_reg, m_err_reg;
    logic [CNT_W-1:0]  m_len_reg;

    logic              emit_fire, last_row, row_has;
    logic [CNT_W-1:0]  cnt_inc, row_len;
    logic [BYTE_W-1:0] row_data;

    always_comb begin
        row_has   = (w_left_reg != '0);
        last_row  = (w_left_reg <= NB_W'(1));
        cnt_inc   = (byte_cnt_reg == '1) ? byte_cnt_reg : byte_cnt_reg + CNT_W'(1);
        row_len   = row_has ? cnt_inc : byte_cnt_reg;
        row_data  = row_has ? w_word_reg[CODE_W-1 -: BYTE_W] : '0;
        emit_fire = w_valid_reg && (!m_valid_reg || m_ready);
        item_take = !w_valid_reg || (emit_fire && last_row);

        w_valid_next  = w_valid_reg;
        w_word_next   = w_word_reg;
        w_left_next   = w_left_reg;
        w_err_next    = w_err_reg;
        w_clear_next  = w_clear_reg;
        byte_cnt_next = byte_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        if (emit_fire) begin
            m_valid_next  = 1'b1;
            byte_cnt_next = (w_clear_reg && last_row) ? '0 : row_len;
            w_word_next   = w_word_reg << BYTE_W;
            if (row_has) begin
                w_left_next = w_left_reg - NB_W'(1);
            end
        end

        if (item_take) begin
            w_valid_next = item_valid;
            w_word_next  = item.word;
            w_left_next  = item.nbytes;
            w_err_next   = item.err;
            w_clear_next = item.clear_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_valid_reg  <= 1'b0;
            byte_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            w_valid_reg  <= w_valid_next;
            byte_cnt_reg <= byte_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_word_reg  <= w_word_next;
        w_left_reg  <= w_left_next;
        w_err_reg   <= w_err_next;
        w_clear_reg <= w_clear_next;
        if (emit_fire) begin
            m_data_reg <= row_data;
            m_has_reg  <= row_has;
            m_last_reg <= last_row;
            m_len_reg  <= row_len;
            m_err_reg  <= w_err_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_data_byte      = m_data_reg;
    assign m_has_byte       = m_has_reg;
    assign m_run_last       = m_last_reg;
    assign m_payload_length = m_len_reg;
    assign m_length_error   = m_err_reg;

endmodule

`default_nettype wire

### rtl/prefix_code_bit_packer.sv
// Top level of the prefix code bit packer: code table, bit alignment, byte emitter.
// Depends on pcbp_pkg, pcbp_code_table, pcbp_bit_align, pcbp_byte_emit.
//
//  channel | ports                                        | word
//  s_      | s_valid/s_ready, operation symbol code len   | load, encode or flush
//  m_      | m_valid/m_ready, byte has last length error  | one result row
//
// Load, flush and an encode without a full byte each give one result; an encode
// gives one result per completed byte (1 to 4), one per cycle from the byte
// emitter while m_ready is high. The first result passes the input stage
// register, the emitter word register and the output register; with one-result
// items and no output stall an item is accepted every cycle. Reset clears the
// table valid bits at once, no clearing pass. Stalls on m_ back up through the emitter and input stage to s_ready.
`default_nettype none

module prefix_code_bit_packer #(
    parameter int SYMBOL_COUNT = 256
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire [pcbp_pkg::OP_W-1:0]     s_operation,
    input  wire [pcbp_pkg::SYM_W-1:0]    s_symbol,
    input  wire [pcbp_pkg::CODE_W-1:0]   s_code_bits,
    input  wire [pcbp_pkg::LEN_W-1:0]    s_code_length,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [pcbp_pkg::BYTE_W-1:0]  m_data_byte,
    output logic                         m_has_byte,
    output logic                         m_run_last,
    output logic [pcbp_pkg::CNT_W-1:0]   m_payload_length,
    output logic                         m_length_error
);
    import pcbp_pkg::*;

    localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam logic [SYM_W:0] SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);

    logic        s_accept, len_err, in_range, tbl_wr;
    entry_t      wr_entry, tbl_entry;
    logic        item_valid, item_take;
    emit_item_t  item;

    always_comb begin
        s_accept = s_valid && s_ready;
        len_err  = (s_code_length > LEN_W'(MAX_CODE_LEN));
        in_range = ({1'b0, s_symbol} < SYM_LIMIT);
        tbl_wr   = s_accept && (s_operation == OP_LOAD) && !len_err && in_range;
        wr_entry.len  = s_code_length;
        wr_entry.code = s_code_bits & ~({CODE_W{1'b1}} << s_code_length);
    end

    pcbp_code_table #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .IDX_W        (IDX_W)
    ) u_table (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_en       (tbl_wr),
        .wr_idx      (s_symbol[IDX_W-1:0]),
        .wr_entry    (wr_entry),
        .rd_en       (s_accept),
        .rd_idx      (s_symbol[IDX_W-1:0]),
        .rd_in_range (in_range),
        .rd_entry    (tbl_entry)
    );

    pcbp_bit_align u_align (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid && (s_operation != OP_NONE)),
        .in_op      (s_operation),
        .in_err     (len_err),
        .in_ready   (s_ready),
        .tbl_entry  (tbl_entry),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    pcbp_byte_emit u_emit (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .item_valid       (item_valid),
        .item             (item),
        .item_take        (item_take),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data_byte      (m_data_byte),
        .m_has_byte       (m_has_byte),
        .m_run_last       (m_run_last),
        .m_payload_length (m_payload_length),
        .m_length_error   (m_length_error)
    );

endmodule

`default_nettype wire

### rtl/pcbp_checker.sv
// Port-level checker for the prefix code bit packer, bound to the top level.
// Depends on prefix_code_bit_packer_assert.svh.
`default_nettype none

`include "prefix_code_bit_packer_assert.svh"

module pcbp_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_valid,
    input wire        m_ready,
    input wire [7:0]  m_data_byte,
    input wire        m_has_byte,
    input wire        m_run_last,
    input wire [31:0] m_payload_length,
    input wire        m_length_error
);

    `PCBP_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data_byte) && $stable(m_has_byte) && $stable(m_run_last) && $stable(m_payload_length))

    `PCBP_ASSERT_NOW(a_empty_byte_zero, m_valid && !m_has_byte, m_data_byte == 8'd0)

    `PCBP_ASSERT_NOW(a_err_single_row, m_valid && m_length_error, m_run_last && !m_has_byte)

    // bytes of one encode follow each other with a count one higher
    `PCBP_ASSERT_NEXT(a_count_steps, m_valid && m_ready && m_has_byte && !m_run_last && (m_payload_length != 32'hFFFF_FFFF), !m_valid || (m_has_byte && (m_payload_length == $past(m_payload_length) + 32'd1)))

endmodule

bind prefix_code_bit_packer pcbp_checker u_pcbp_checker (.*);

`default_nettype wire

### verif/prefix_code_bit_packer_checker.sv
// Scoreboard for the prefix code bit packer: watches both channels, predicts result rows
// from accepted input words and compares every accepted result row field by field.
// Depends on pcbp_pkg.
`timescale 1ns / 100ps

module prefix_code_bit_packer_checker
    import pcbp_pkg::*;
(
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    input  wire                s_ready,
    input  wire [OP_W-1:0]     s_operation,
    input  wire [SYM_W-1:0]    s_symbol,
    input  wire [CODE_W-1:0]   s_code_bits,
    input  wire [LEN_W-1:0]    s_code_length,
    input  wire                m_valid,
    input  wire                m_ready,
    input  wire [BYTE_W-1:0]   m_data_byte,
    input  wire                m_has_byte,
    input  wire                m_run_last,
    input  wire [CNT_W-1:0]    m_payload_length,
    input  wire                m_length_error,
    output int                 fail_count,
    output int                 rows_waiting,
    output int                 rows_checked,
    output int                 words_taken
);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              has;
        logic              last;
        logic [CNT_W-1:0]  plen;
        logic              err;
    } row_t;

    row_t              rows_due[$];
    logic [CODE_W-1:0] code_tbl[256];
    logic [LEN_W-1:0]  len_tbl[256];
    logic [PEND_W-1:0] pend_bits;
    logic [PCNT_W-1:0] pend_cnt;
    logic [CNT_W-1:0]  blk_bytes;

    initial begin
        fail_count   = 0;
        rows_waiting = 0;
        rows_checked = 0;
        words_taken  = 0;
    end

    function automatic void count_block_byte();
        if (blk_bytes != '1) begin
            blk_bytes = blk_bytes + 1'b1;
        end
    endfunction

    function automatic void pack_rows(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                                      input logic [CODE_W-1:0] code,
                                      input logic [LEN_W-1:0] len);
        row_t          r;
        logic [63:0]   mask;
        logic [38:0]   acc;
        int            clen;
        int            total;
        r = '0;
        case (op)
            OP_LOAD: begin
                r.last = 1'b1;
                r.err  = (len > MAX_CODE_LEN);
                if (!r.err) begin
                    mask = (64'd1 << len) - 64'd1;
                    code_tbl[sym] = code & mask[31:0];
                    len_tbl[sym]  = len;
                end
                r.plen = blk_bytes;
                rows_due.push_back(r);
            end
            OP_ENCODE: begin
                clen = len_tbl[sym];
                if (clen > 32) begin
                    clen = 32;
                end
                acc   = ({32'd0, pend_bits} << clen) | {7'd0, code_tbl[sym]};
                total = pend_cnt + clen;
                if (total < 8) begin
                    r.last = 1'b1;
                    r.plen = blk_bytes;
                    rows_due.push_back(r);
                end
                while (total >= 8) begin
                    r.data = 8'(acc >> (total - 8));
                    total  = total - 8;
                    count_block_byte();
                    r.has  = 1'b1;
                    r.last = (total < 8);
                    r.plen = blk_bytes;
                    rows_due.push_back(r);
                end
                pend_cnt  = 3'(total);
                pend_bits = 7'(acc & ((39'd1 << total) - 39'd1));
            end
            OP_FLUSH: begin
                r.last = 1'b1;
                if (pend_cnt != 0) begin
                    r.data = 8'({1'b0, pend_bits} << (8 - pend_cnt));
                    r.has  = 1'b1;
                    count_block_byte();
                end
                r.plen = blk_bytes;
                rows_due.push_back(r);
                pend_bits = '0;
                pend_cnt  = '0;
                blk_bytes = '0;
            end
            default: ;
        endcase
    endfunction

    always @(posedge aclk) begin : watch
        row_t want;
        if (!aresetn) begin
            for (int i = 0; i < 256; i++) begin
                code_tbl[i] = '0;
                len_tbl[i]  = '0;
            end
            pend_bits = '0;
            pend_cnt  = '0;
            blk_bytes = '0;
            rows_due.delete();
        end else begin
            if (s_valid && s_ready) begin
                words_taken++;
                pack_rows(s_operation, s_symbol, s_code_bits, s_code_length);
            end
            if (m_valid && m_ready) begin
                rows_checked++;
                if (rows_due.size() == 0) begin
                    $error("result row with no expected row: data_byte %0h", m_data_byte);
                    fail_count++;
                end else begin
                    want = rows_due.pop_front();
                    if (m_data_byte !== want.data) begin
                        $error("data_byte: expected %0h, actual %0h", want.data, m_data_byte);
                        fail_count++;
                    end
                    if (m_has_byte !== want.has) begin
                        $error("has_byte: expected %0b, actual %0b", want.has, m_has_byte);
                        fail_count++;
                    end
                    if (m_run_last !== want.last) begin
                        $error("run_last: expected %0b, actual %0b", want.last, m_run_last);
                        fail_count++;
                    end
                    if (m_payload_length !== want.plen) begin
                        $error("payload_length: expected %0d, actual %0d",
                               want.plen, m_payload_length);
                        fail_count++;
                    end
                    if (m_length_error !== want.err) begin
                        $error("length_error: expected %0b, actual %0b",
                               want.err, m_length_error);
                        fail_count++;
                    end
                end
            end
        end
        rows_waiting = rows_due.size();
    end

endmodule

### verif/prefix_code_bit_packer_test.sv
// Testbench top for the prefix code bit packer: clock, reset, word stimulus and
// result-side back-pressure; checking is done by prefix_code_bit_packer_checker.
// Depends on pcbp_pkg, prefix_code_bit_packer and prefix_code_bit_packer_checker.
`timescale 1ns / 100ps

module prefix_code_bit_packer_test;
    import pcbp_pkg::*;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_operation   = OP_LOAD;
    logic [SYM_W-1:0]    s_symbol      = '0;
    logic [CODE_W-1:0]   s_code_bits   = '0;
    logic [LEN_W-1:0]    s_code_length = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [BYTE_W-1:0]   m_data_byte;
    logic                m_has_byte;
    logic                m_run_last;
    logic [CNT_W-1:0]    m_payload_length;
    logic                m_length_error;

    int                  fail_count;
    int                  rows_waiting;
    int                  rows_checked;
    int                  words_taken;

    bit                  tx_idle_en = 1'b1;
    bit                  rx_idle_en = 1'b1;
    int                  hold_reqs  = 0;
    int                  hold_done  = 0;
    int                  words_sent = 0;
    logic [SYM_W-1:0]    coded_syms[$];

    always #10 aclk = ~aclk;

    prefix_code_bit_packer u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_symbol         (s_symbol),
        .s_code_bits      (s_code_bits),
        .s_code_length    (s_code_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data_byte      (m_data_byte),
        .m_has_byte       (m_has_byte),
        .m_run_last       (m_run_last),
        .m_payload_length (m_payload_length),
        .m_length_error   (m_length_error)
    );

    prefix_code_bit_packer_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_symbol         (s_symbol),
        .s_code_bits      (s_code_bits),
        .s_code_length    (s_code_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data_byte      (m_data_byte),
        .m_has_byte       (m_has_byte),
        .m_run_last       (m_run_last),
        .m_payload_length (m_payload_length),
        .m_length_error   (m_length_error),
        .fail_count       (fail_count),
        .rows_waiting     (rows_waiting),
        .rows_checked     (rows_checked),
        .words_taken      (words_taken)
    );

    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: short random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_reqs != hold_done) begin
                hold_done++;
                m_ready <= 1'b0;
                repeat (79) @(posedge aclk);
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic offer_word(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                              input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_symbol      <= sym;
        s_code_bits   <= code;
        s_code_length <= len;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op != OP_NONE) begin
            words_sent++;
        end
        if (op == OP_LOAD && len != 0 && len <= MAX_CODE_LEN) begin
            coded_syms.push_back(sym);
        end
    endtask

    task automatic offer_random_word();
        int               pick;
        logic [OP_W-1:0]  op;
        logic [SYM_W-1:0] sym;
        logic [LEN_W-1:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            op = OP_LOAD;
        end else if (pick < 85) begin
            op = OP_ENCODE;
        end else if (pick < 95) begin
            op = OP_FLUSH;
        end else begin
            op = OP_NONE;
        end
        case ($urandom_range(0, 9))
            0:             len = '0;
            1, 2, 3, 4, 5, 6: len = 6'($urandom_range(1, 16));
            7, 8:          len = 6'($urandom_range(17, 32));
            default:       len = 6'($urandom_range(33, 63));
        endcase
        sym = 8'($urandom_range(0, 255));
        if (op == OP_ENCODE && coded_syms.size() > 0 && $urandom_range(0, 4) != 0) begin
            sym = coded_syms[$urandom_range(0, coded_syms.size() - 1)];
        end
        offer_word(op, sym, $urandom, len);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, masking, length extremes, rejected loads, flushes
        offer_word(OP_ENCODE, 8'h00, 32'h0, 6'd0);
        offer_word(OP_FLUSH,  8'h00, 32'h0, 6'd0);
        offer_word(OP_LOAD,   8'h41, 32'hFFFF_FFFD, 6'd3);
        offer_word(OP_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32);
        offer_word(OP_LOAD,   8'h00, 32'hFFFF_FFFE, 6'd1);
        offer_word(OP_LOAD,   8'h80, 32'h1234_56A5, 6'd8);
        offer_word(OP_LOAD,   8'h10, 32'hFFFF_FFFF, 6'd33);
        offer_word(OP_LOAD,   8'h11, 32'hDEAD_BEEF, 6'd63);
        offer_word(OP_LOAD,   8'h12, 32'hFFFF_FFFF, 6'd0);
        offer_word(OP_ENCODE, 8'h12, 32'h0, 6'd0);
        offer_word(OP_ENCODE, 8'h10, 32'h0, 6'd0);
        offer_word(OP_ENCODE, 8'h41, 32'h0, 6'd0);
        offer_word(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
        offer_word(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
        offer_word(OP_NONE,   8'hFF, 32'hFFFF_FFFF, 6'd63);
        offer_word(OP_ENCODE, 8'h80, 32'h0, 6'd0);
        offer_word(OP_ENCODE, 8'h00, 32'h0, 6'd0);
        offer_word(OP_FLUSH,  8'h00, 32'h0, 6'd0);
        offer_word(OP_FLUSH,  8'h00, 32'h0, 6'd0);
        offer_word(OP_LOAD,   8'h07, 32'h0000_007F, 6'd7);
        offer_word(OP_ENCODE, 8'h07, 32'h0, 6'd0);
        offer_word(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
        offer_word(OP_FLUSH,  8'h00, 32'h0, 6'd0);

        while (words_sent < 130) offer_random_word();

        // long output hold-off while full-length codes keep arriving
        offer_word(OP_LOAD, 8'hFF, $urandom, 6'd32);
        hold_reqs++;
        repeat (20) offer_word(OP_ENCODE, 8'hFF, 32'h0, 6'd0);

        while (words_sent < 190) offer_random_word();

        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        while (words_sent < 210) offer_random_word();
        offer_word(OP_FLUSH, 8'h00, 32'h0, 6'd0);
        s_valid <= 1'b0;

        while (rows_waiting != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("Run covered %0d input words (loads, encodes, flushes, rejected lengths)",
                 words_taken);
        $display("and %0d result rows, including a long output stall.", rows_checked);
        if (fail_count == 0 && rows_waiting == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/pcbp_pkg.sv
rtl/pcbp_code_table.sv
rtl/pcbp_bit_align.sv
rtl/pcbp_byte_emit.sv
rtl/prefix_code_bit_packer.sv
rtl/pcbp_checker.sv
verif/prefix_code_bit_packer_checker.sv
verif/prefix_code_bit_packer_test.sv
